// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; NO_ASSERTIONS turns every check into nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define MQ_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define MQ_ASSERT(label, clk, rstn, prop, msg)
`define MQ_ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

// ===== hw/rtl/mqlp_pkg.sv =====
// types, codes and constants of the marked quoted-list parser
// used by mqlp_step and marked_quoted_list_parser; no dependencies
package mqlp_pkg;

    localparam int MARKER_LEN_DEFAULT = 33;
    localparam int MAX_ARGS_DEFAULT   = 255;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;

    typedef enum logic [2:0] {
        PH_MARKER  = 3'd0,
        PH_BRACKET = 3'd1,
        PH_QUOTE   = 3'd2,
        PH_ARG     = 3'd3,
        PH_SEP     = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_BYTE = 3'd1,
        KIND_END  = 3'd2,
        KIND_DONE = 3'd3,
        KIND_ERR  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_MARKER  = 3'd0,
        ERR_BRACKET = 3'd1,
        ERR_QUOTE   = 3'd2,
        ERR_SEP     = 3'd3,
        ERR_TRUNC   = 3'd4
    } err_t;

    typedef struct packed {
        phase_t      phase;
        logic [5:0]  marker_pos;
        logic        escape_pending;
        logic [7:0]  arg_counter;
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [7:0]  arg_number;
        err_t        error_code;
    } result_t;

    // fixed 33-byte start marker as ascii codes; positions past it read as zero
    function automatic logic [7:0] marker_byte(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:  b = 8'h45;
            6'd1:  b = 8'h58;
            6'd2:  b = 8'h45;
            6'd3:  b = 8'h43;
            6'd4:  b = 8'h5F;
            6'd5:  b = 8'h52;
            6'd6:  b = 8'h55;
            6'd7:  b = 8'h4E;
            6'd8:  b = 8'h4E;
            6'd9:  b = 8'h45;
            6'd10: b = 8'h52;
            6'd11: b = 8'h5F;
            6'd12: b = 8'h57;
            6'd13: b = 8'h52;
            6'd14: b = 8'h41;
            6'd15: b = 8'h50;
            6'd16: b = 8'h50;
            6'd17: b = 8'h45;
            6'd18: b = 8'h52;
            6'd19: b = 8'h5F;
            6'd20: b = 8'h43;
            6'd21: b = 8'h4F;
            6'd22: b = 8'h4E;
            6'd23: b = 8'h46;
            6'd24: b = 8'h49;
            6'd25: b = 8'h47;
            6'd26: b = 8'h5F;
            6'd27: b = 8'h4D;
            6'd28: b = 8'h41;
            6'd29: b = 8'h52;
            6'd30: b = 8'h4B;
            6'd31: b = 8'h45;
            6'd32: b = 8'h52;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/mqlp_step.sv =====
// one-byte state transition of the quoted-list parser (combinational)
// depends on mqlp_pkg for the state and result structs and the codes
module mqlp_step #(
    parameter int MARKER_LEN = mqlp_pkg::MARKER_LEN_DEFAULT,
    parameter int MAX_ARGS   = mqlp_pkg::MAX_ARGS_DEFAULT
) (
    input  mqlp_pkg::state_t  cur,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    output mqlp_pkg::state_t  nxt,
    output mqlp_pkg::result_t res
);

    localparam logic [5:0] MarkerLenW = 6'(MARKER_LEN);
    localparam logic [7:0] ArgCap     = (MAX_ARGS > 255) ? 8'd255 : 8'(MAX_ARGS);

    logic [5:0] pos_inc;
    logic       active;

    assign pos_inc = cur.marker_pos + 6'd1;

    always_comb begin
        nxt            = cur;
        res.kind       = mqlp_pkg::KIND_NONE;
        res.out_byte   = 8'd0;
        res.arg_number = 8'd0;
        res.error_code = mqlp_pkg::ERR_MARKER;
        active         = 1'b1;
        case (cur.phase)
            mqlp_pkg::PH_MARKER: begin
                if (data_byte != mqlp_pkg::marker_byte(cur.marker_pos)) begin
                    res.kind   = mqlp_pkg::KIND_ERR;
                    nxt.phase  = mqlp_pkg::PH_ERROR;
                end else begin
                    nxt.marker_pos = pos_inc;
                    if (pos_inc >= MarkerLenW) begin
                        nxt.phase = mqlp_pkg::PH_BRACKET;
                    end
                end
            end
            mqlp_pkg::PH_BRACKET: begin
                if (data_byte == mqlp_pkg::CH_LBRACKET) begin
                    nxt.phase = mqlp_pkg::PH_QUOTE;
                end else begin
                    res.kind       = mqlp_pkg::KIND_ERR;
                    res.error_code = mqlp_pkg::ERR_BRACKET;
                    nxt.phase      = mqlp_pkg::PH_ERROR;
                end
            end
            mqlp_pkg::PH_QUOTE: begin
                if (data_byte == mqlp_pkg::CH_QUOTE) begin
                    nxt.phase          = mqlp_pkg::PH_ARG;
                    nxt.escape_pending = 1'b0;
                end else begin
                    res.kind       = mqlp_pkg::KIND_ERR;
                    res.error_code = mqlp_pkg::ERR_QUOTE;
                    nxt.phase      = mqlp_pkg::PH_ERROR;
                end
            end
            mqlp_pkg::PH_ARG: begin
                if (cur.escape_pending || data_byte[7]) begin
                    nxt.escape_pending = 1'b0;
                    res.kind           = mqlp_pkg::KIND_BYTE;
                    res.out_byte       = data_byte;
                    res.arg_number     = cur.arg_counter;
                end else if (data_byte == mqlp_pkg::CH_BSLASH) begin
                    nxt.escape_pending = 1'b1;
                end else if (data_byte == mqlp_pkg::CH_QUOTE) begin
                    res.kind       = mqlp_pkg::KIND_END;
                    res.arg_number = cur.arg_counter;
                    if (cur.arg_counter < ArgCap) begin
                        nxt.arg_counter = cur.arg_counter + 8'd1;
                    end
                    nxt.phase = mqlp_pkg::PH_SEP;
                end else begin
                    res.kind       = mqlp_pkg::KIND_BYTE;
                    res.out_byte   = data_byte;
                    res.arg_number = cur.arg_counter;
                end
            end
            mqlp_pkg::PH_SEP: begin
                if (data_byte == mqlp_pkg::CH_COMMA) begin
                    nxt.phase = mqlp_pkg::PH_QUOTE;
                end else if (data_byte == mqlp_pkg::CH_RBRACKET) begin
                    res.kind       = mqlp_pkg::KIND_DONE;
                    res.arg_number = cur.arg_counter;
                    nxt.phase      = mqlp_pkg::PH_DONE;
                end else begin
                    res.kind       = mqlp_pkg::KIND_ERR;
                    res.error_code = mqlp_pkg::ERR_SEP;
                    nxt.phase      = mqlp_pkg::PH_ERROR;
                end
            end
            mqlp_pkg::PH_DONE: begin
                active = 1'b0;
            end
            default: begin
                // error is sticky, and any stray code falls into it
                active    = 1'b0;
                nxt.phase = mqlp_pkg::PH_ERROR;
            end
        endcase

        // last byte with the list still open overrides whatever this byte produced
        if (active && final_byte && nxt.phase != mqlp_pkg::PH_DONE
                && nxt.phase != mqlp_pkg::PH_ERROR) begin
            res.kind       = mqlp_pkg::KIND_ERR;
            res.out_byte   = 8'd0;
            res.arg_number = 8'd0;
            res.error_code = mqlp_pkg::ERR_TRUNC;
            nxt.phase      = mqlp_pkg::PH_ERROR;
        end
    end

endmodule

// ===== hw/rtl/marked_quoted_list_parser.sv =====
// top level of the marked quoted-list parser: parser state and result register
// depends on mqlp_pkg, mqlp_step and assert_macros.svh
//
// Takes one stream byte per transfer and returns exactly one result transfer
// for each byte, in order. After a fixed start marker of MARKER_LEN bytes and
// '[', it reads a list of double-quoted arguments separated by ',' and closed
// by ']'; a backslash makes the next byte literal. Each content byte comes out
// with kind 1 and its argument index, a closing quote with kind 2, the closing
// bracket with kind 3 and the argument count, an error with kind 4 and its
// code; other bytes give kind 0. s_tlast marks the last byte of the stream.
// Once the list is complete or an error is reported, later bytes give kind 0
// until reset. Throughput is one byte per cycle unless stalled; a result shows
// in the cycle after its byte: all decode sits between the state registers and
// the result register; s_tready is low only while a held result is not taken.
`include "assert_macros.svh"

module marked_quoted_list_parser #(
    parameter int MARKER_LEN = mqlp_pkg::MARKER_LEN_DEFAULT,
    parameter int MAX_ARGS   = mqlp_pkg::MAX_ARGS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [15:8] arg_number,
                                   // [18:16] error_code, [23:19] zero
    output logic [2:0]  m_tuser    // [2:0] kind
);

    localparam logic [5:0] MarkerLenW = 6'(MARKER_LEN);
    localparam logic [7:0] ArgCap     = (MAX_ARGS > 255) ? 8'd255 : 8'(MAX_ARGS);

    mqlp_pkg::state_t  state_reg;
    mqlp_pkg::state_t  state_next;
    mqlp_pkg::result_t step_res;
    mqlp_pkg::result_t result_reg;
    logic              m_valid_reg;
    logic              in_xfer;

    assign s_tready = ~m_valid_reg | m_tready;
    assign in_xfer  = s_tvalid & s_tready;

    mqlp_step #(
        .MARKER_LEN (MARKER_LEN),
        .MAX_ARGS   (MAX_ARGS)
    ) u_step (
        .cur        (state_reg),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .nxt        (state_next),
        .res        (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= mqlp_pkg::PH_MARKER;
            state_reg.marker_pos     <= 6'd0;
            state_reg.escape_pending <= 1'b0;
            state_reg.arg_counter    <= 8'd0;
            m_valid_reg              <= 1'b0;
        end else begin
            if (in_xfer) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            result_reg <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.kind;
    assign m_tdata  = {5'd0, result_reg.error_code, result_reg.arg_number,
                       result_reg.out_byte};

    `MQ_ASSERT(a_error_sticky, aclk, aresetn,
        state_reg.phase == mqlp_pkg::PH_ERROR |=> state_reg.phase == mqlp_pkg::PH_ERROR,
        "error phase left without reset")
    `MQ_ASSERT(a_done_sticky, aclk, aresetn,
        state_reg.phase == mqlp_pkg::PH_DONE |=> state_reg.phase == mqlp_pkg::PH_DONE,
        "done phase left without reset")
    `MQ_ASSERT(a_err_enters_error, aclk, aresetn,
        in_xfer && step_res.kind == mqlp_pkg::KIND_ERR |=>
            state_reg.phase == mqlp_pkg::PH_ERROR && m_tuser == mqlp_pkg::KIND_ERR,
        "error result without error phase")
    `MQ_ASSERT(a_marker_pos_range, aclk, aresetn,
        state_reg.phase == mqlp_pkg::PH_MARKER |-> state_reg.marker_pos < MarkerLenW,
        "marker position past marker length")
    `MQ_ASSERT_NEVER(a_arg_counter_cap, aclk, aresetn,
        state_reg.arg_counter > ArgCap,
        "argument counter above its cap")

endmodule
